[hdl/spf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the servo packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] LEN_EXTRA = 8'd2;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte positions within a packet as the back part walks them.
    localparam logic [2:0] STEP_HDR0  = 3'd0;
    localparam logic [2:0] STEP_HDR1  = 3'd1;
    localparam logic [2:0] STEP_ID    = 3'd2;
    localparam logic [2:0] STEP_LEN   = 3'd3;
    localparam logic [2:0] STEP_INSTR = 3'd4;
    localparam logic [2:0] STEP_PARAM = 3'd5;
    localparam logic [2:0] STEP_CHK   = 3'd6;

    // One classified input word, ready for the back part to serialize.
    typedef struct packed {
        logic       is_start;
        logic       has_param;
        logic       is_last;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] instr;
        logic [7:0] param;
        logic [7:0] chk;
    } cmd_t;

endpackage
`default_nettype wire

[hdl/spf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_front
// Accepts input words, tracks the open packet and builds back-end commands.
// ----------------------------------------------------------------------------
module spf_front
    import spf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       start_packet,
    input  wire logic [7:0] node_id,
    input  wire logic [7:0] instruction_code,
    input  wire logic [7:0] param_count,
    input  wire logic [7:0] param_byte,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            push_cmd
);

    logic       open_reg, open_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] sum_reg, sum_next;

    logic       accept;
    logic [7:0] len;
    logic [7:0] head_sum;
    logic [7:0] base_sum;
    logic [7:0] base_left;
    logic [7:0] param_sum;
    logic [7:0] param_left;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        len        = param_count + LEN_EXTRA;
        head_sum   = node_id + len + instruction_code;
        base_sum   = start_packet ? head_sum : sum_reg;
        base_left  = start_packet ? param_count : left_reg;
        param_sum  = base_sum + param_byte;
        param_left = base_left - 8'd1;

        open_next = open_reg;
        left_next = left_reg;
        sum_next  = sum_reg;

        push               = accept && (start_packet || open_reg);
        push_cmd.is_start  = start_packet;
        push_cmd.id        = node_id;
        push_cmd.len       = len;
        push_cmd.instr     = instruction_code;
        push_cmd.param     = param_byte;

        if (start_packet && (param_count == 8'd0))
        begin
            push_cmd.has_param = 1'b0;
            push_cmd.is_last   = 1'b1;
            push_cmd.chk       = ~head_sum;
        end
        else
        begin
            push_cmd.has_param = 1'b1;
            push_cmd.is_last   = (param_left == 8'd0);
            push_cmd.chk       = ~param_sum;
        end

        if (push)
        begin
            if (start_packet && (param_count == 8'd0))
            begin
                open_next = 1'b0;
                left_next = 8'd0;
                sum_next  = head_sum;
            end
            else
            begin
                open_next = (param_left != 8'd0);
                left_next = param_left;
                sum_next  = param_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 8'd0;
            sum_reg  <= 8'd0;
        end
        else
        begin
            open_reg <= open_next;
            left_reg <= left_next;
            sum_reg  <= sum_next;
        end
    end

endmodule
`default_nettype wire

[hdl/spf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_queue
// Short command queue that lets the front and back parts stall independently.
// ----------------------------------------------------------------------------
module spf_queue
    import spf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[hdl/spf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_back
// Serializes queued commands into packet bytes through an output register.
// ----------------------------------------------------------------------------
module spf_back
    import spf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  cmd_t            cmd,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            end_of_packet
);

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       eop_reg;

    logic       load;
    logic       fire;
    logic [2:0] cur_step;
    logic [2:0] inc_step;
    logic       done;
    logic [7:0] byte_val;

    assign load = !valid_reg || !out_stall;
    assign fire = cmd_valid && load;

    always_comb
    begin
        // A parameter-only command begins directly at the parameter byte.
        cur_step = ((step_reg == STEP_HDR0) && !cmd.is_start) ? STEP_PARAM : step_reg;
        inc_step = cur_step + 3'd1;
        done     = 1'b0;
        if ((inc_step == STEP_PARAM) && !cmd.has_param)
        begin
            inc_step = STEP_CHK;
        end
        if ((inc_step == STEP_CHK) && !cmd.is_last)
        begin
            done = 1'b1;
        end
        if (cur_step == STEP_CHK)
        begin
            done = 1'b1;
        end

        unique case (cur_step)
            STEP_HDR0:  byte_val = HDR_BYTE;
            STEP_HDR1:  byte_val = HDR_BYTE;
            STEP_ID:    byte_val = cmd.id;
            STEP_LEN:   byte_val = cmd.len;
            STEP_INSTR: byte_val = cmd.instr;
            STEP_PARAM: byte_val = cmd.param;
            STEP_CHK:   byte_val = cmd.chk;
            default:    byte_val = cmd.chk;
        endcase

        pop       = fire && done;
        step_next = step_reg;
        if (fire)
        begin
            step_next = done ? STEP_HDR0 : inc_step;
        end

        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_val;
            eop_reg  <= (cur_step == STEP_CHK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_HDR0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign end_of_packet = eop_reg;

endmodule
`default_nettype wire

[hdl/servo_packet_framer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// servo_packet_framer_unit
// Frames servo-bus (protocol 1) instruction packets as a byte stream.
// ----------------------------------------------------------------------------
// A start word produces the header 0xFF 0xFF, the id, the length (count + 2)
// and the instruction, then its first parameter if the count is nonzero;
// each later word passes one parameter byte, and the checksum byte follows
// the last parameter with end_of_packet set. The front part takes one input
// word per cycle into a four-entry command queue and stalls only when that
// queue is full; the back part drives one output byte per cycle from its
// output register while a command waits and out_stall is low. A parameter
// word yields one output byte (two for the last one), a start word six or
// seven, so parameters stream at one byte per cycle and headers burst out.
// Words that are not starts while no packet is open are dropped.
module servo_packet_framer_unit
    import spf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       start_packet,
    input  wire logic [7:0] node_id,
    input  wire logic [7:0] instruction_code,
    input  wire logic [7:0] param_count,
    input  wire logic [7:0] param_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            end_of_packet
);

    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_full;
    logic q_not_empty;
    cmd_t head_cmd;

    spf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_packet     (start_packet),
        .node_id          (node_id),
        .instruction_code (instruction_code),
        .param_count      (param_count),
        .param_byte       (param_byte),
        .q_full           (q_full),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    spf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    spf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_not_empty),
        .cmd           (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .end_of_packet (end_of_packet)
    );

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the servo packet framer.
// ----------------------------------------------------------------------------
// Input words go in through a valid/stall handshake. A small scoreboard frames
// each accepted word the way the wire protocol defines it and queues the bytes
// that are due. Each accepted output byte is checked against the oldest one.
// A directed opening covers zero and one-parameter packets, field extremes,
// length wrap, abandoned packets and dropped words. Random packets follow,
// mostly well formed, with broken and stray words mixed in. Both sides idle
// in short bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb
    import spf_pkg::*;
();

    localparam logic [7:0] BROADCAST_ID = 8'd254;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       eop;
    } wire_byte_t;

    // Frames accepted words into the bytes due on the wire and checks them.
    class packet_byte_board;
        wire_byte_t bytes_due[$];
        logic       pkt_open;
        logic [7:0] params_left;
        logic [7:0] frame_sum;
        int         words_framed;
        int         packets_opened;
        int         bytes_checked;
        int         faults;

        function new();
            pkt_open       = 1'b0;
            params_left    = 8'd0;
            frame_sum      = 8'd0;
            words_framed   = 0;
            packets_opened = 0;
            bytes_checked  = 0;
            faults         = 0;
        endfunction

        function void queue_byte(input logic [7:0] b, input logic eop);
            wire_byte_t wb;
            wb.data = b;
            wb.eop  = eop;
            bytes_due.push_back(wb);
        endfunction

        function void pass_param(input logic [7:0] p);
            queue_byte(p, 1'b0);
            frame_sum   = frame_sum + p;
            params_left = params_left - 8'd1;
            if (params_left == 8'd0)
            begin
                queue_byte(~frame_sum, 1'b1);
                pkt_open = 1'b0;
            end
        endfunction

        function void frame_word(input logic s, input logic [7:0] id, input logic [7:0] instr,
                                 input logic [7:0] cnt, input logic [7:0] prm);
            logic [7:0] len;
            if (s)
            begin
                words_framed++;
                packets_opened++;
                len = cnt + LEN_EXTRA;
                queue_byte(HDR_BYTE, 1'b0);
                queue_byte(HDR_BYTE, 1'b0);
                queue_byte(id, 1'b0);
                queue_byte(len, 1'b0);
                queue_byte(instr, 1'b0);
                frame_sum   = id + len + instr;
                params_left = cnt;
                if (cnt == 8'd0)
                begin
                    queue_byte(~frame_sum, 1'b1);
                    pkt_open = 1'b0;
                end
                else
                begin
                    pkt_open = 1'b1;
                    pass_param(prm);
                end
            end
            else if (pkt_open)
            begin
                words_framed++;
                pass_param(prm);
            end
        endfunction

        function void check_byte(input logic [7:0] b, input logic eop);
            wire_byte_t due;
            bytes_checked++;
            if (bytes_due.size() == 0)
            begin
                $display("%0t: byte %02h (eop %0b) arrived with nothing due", $time, b, eop);
                faults++;
            end
            else
            begin
                due = bytes_due.pop_front();
                if (b !== due.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h", $time, due.data, b);
                    faults++;
                end
                if (eop !== due.eop)
                begin
                    $display("%0t: end_of_packet expected %0b actual %0b", $time, due.eop, eop);
                    faults++;
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       start_packet;
    logic [7:0] node_id;
    logic [7:0] instruction_code;
    logic [7:0] param_count;
    logic [7:0] param_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       end_of_packet;

    packet_byte_board board;
    bit calm         = 1'b0;
    bit hold_off_req = 1'b0;
    int input_stall_cycles = 0;

    servo_packet_framer_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_packet     (start_packet),
        .node_id          (node_id),
        .instruction_code (instruction_code),
        .param_count      (param_count),
        .param_byte       (param_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .end_of_packet    (end_of_packet)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb: run timed out with %0d bytes still due", board.bytes_due.size());
        $display("tb: failure");
        $finish;
    end

    // Offers one word, possibly after a short idle burst, and returns at the
    // edge where it is accepted.
    task automatic send_word(input logic s, input logic [7:0] id, input logic [7:0] instr,
                             input logic [7:0] cnt, input logic [7:0] prm);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        start_packet     <= s;
        node_id          <= id;
        instruction_code <= instr;
        param_count      <= cnt;
        param_byte       <= prm;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // A start word followed by further parameter words, n_words in all.
    task automatic send_packet(input logic [7:0] id, input logic [7:0] instr,
                               input logic [7:0] cnt, input int n_words);
        int k;
        send_word(1'b1, id, instr, cnt, 8'($urandom_range(0, 255)));
        for (k = 1; k < n_words; k++)
            send_word(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin : rx_pace
        int burst;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                // Long hold-off so the command queue fills and the input stalls.
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.frame_word(start_packet, node_id, instruction_code, param_count,
                                 param_byte);
            if (in_stall)
                input_stall_cycles++;
            if (out_valid && !out_stall)
                board.check_byte(out_byte, end_of_packet);
        end
    end

    initial
    begin : stimulus
        int         pick;
        logic [7:0] id;
        logic [7:0] instr;
        logic [7:0] cnt;
        bit         left_open;

        board = new();
        left_open = 1'b0;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        start_packet     <= 1'b0;
        node_id          <= 8'd0;
        instruction_code <= 8'd0;
        param_count      <= 8'd0;
        param_byte       <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-count packets at both field extremes; the parameter is unused.
        send_word(1'b1, 8'h00, 8'h00, 8'd0, 8'h00);
        send_word(1'b1, 8'hFF, 8'hFF, 8'd0, 8'hFF);
        // A stray parameter word with no packet open is dropped.
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Single-parameter packets end on the start word itself.
        send_word(1'b1, BROADCAST_ID, 8'h03, 8'd1, 8'h00);
        send_word(1'b1, 8'h01, 8'hFF, 8'd1, 8'hFF);
        send_word(1'b1, 8'hAA, 8'h55, 8'd3, 8'h5A);
        send_word(1'b0, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Counts of 254 and 255 wrap the length byte; the large-count packets are
        // abandoned by the next start.
        send_word(1'b1, 8'h12, 8'h34, 8'd255, 8'h01);
        send_word(1'b0, 8'h00, 8'h00, 8'h00, 8'h02);
        send_word(1'b0, 8'h00, 8'h00, 8'h00, 8'h03);
        send_word(1'b1, 8'h56, 8'h78, 8'd254, 8'hFF);
        send_word(1'b1, 8'h80, 8'h7F, 8'd253, 8'h00);
        send_word(1'b0, 8'h00, 8'h00, 8'h00, 8'h80);
        send_word(1'b1, 8'hFE, 8'h02, 8'd2, 8'h11);
        send_word(1'b0, 8'h00, 8'h00, 8'h00, 8'h22);
        send_word(1'b0, 8'h55, 8'hAA, 8'h01, 8'h33);

        hold_off_req = 1'b1;
        while (board.words_framed < 190)
        begin
            if (board.words_framed >= 150)
                calm = 1'b1;
            pick  = $urandom_range(0, 19);
            id    = ($urandom_range(0, 7) == 0) ? BROADCAST_ID : 8'($urandom_range(0, 255));
            instr = 8'($urandom_range(0, 255));
            if (!left_open && pick < 3)
            begin
                send_word(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            else if (pick < 6)
            begin
                // Broken packet: stops short and is cut off by the next start.
                cnt = 8'($urandom_range(2, 255));
                send_packet(id, instr, cnt, $urandom_range(1, (cnt > 8'd7) ? 6 : cnt - 1));
                left_open = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       cnt = 8'd0;
                    1:       cnt = 8'd1;
                    2:       cnt = 8'($urandom_range(7, 20));
                    default: cnt = 8'($urandom_range(1, 6));
                endcase
                send_packet(id, instr, cnt, (cnt == 8'd0) ? 1 : int'(cnt));
                left_open = 1'b0;
            end
        end
        in_valid <= 1'b0;

        while (board.bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d words framed into %0d packets, %0d output bytes checked",
                 board.words_framed, board.packets_opened, board.bytes_checked);
        $display("tb: input held back for %0d cycles, %0d mismatches",
                 input_stall_cycles, board.faults);
        if (board.faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
